>>> sv/rmau_pkg.sv
`timescale 1ns / 1ps
// Package for the rotation matrix axial update core: op codes and small types.
// No dependencies; imported by rotation_matrix_axial_update_core.
package rmau_pkg;

  // op field width and op codes (right multiply mixes columns, left mixes rows)
  localparam int unsigned OP_W = 3;

  localparam logic [OP_W-1:0] OP_RIGHT_X = 3'd0;
  localparam logic [OP_W-1:0] OP_RIGHT_Y = 3'd1;
  localparam logic [OP_W-1:0] OP_RIGHT_Z = 3'd2;
  localparam logic [OP_W-1:0] OP_LEFT_X  = 3'd3;
  localparam logic [OP_W-1:0] OP_LEFT_Y  = 3'd4;
  localparam logic [OP_W-1:0] OP_LEFT_Z  = 3'd5;

  // index of a row or column of the 3x3 matrix
  typedef logic [1:0] line_idx_t;

  // decoded op: which two lines mix and along which direction
  typedef struct packed {
    logic      en;     // op mixes anything at all
    logic      left;   // rows mix (left multiply) instead of columns
    line_idx_t p;      // line that gets a*c + b*s
    line_idx_t q;      // line that gets b*c - a*s
  } mix_sel_t;

endpackage

>>> sv/rotation_matrix_axial_update_core.sv
`timescale 1ns / 1ps
// Rotation matrix axial update core: multiplies a 3x3 Q-format matrix by an
// X/Y/Z axis rotation on the right or the left. Depends on rmau_pkg.
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | tuser: op; tdata: matrix, sine, cosine
//  m_axis   | out       | tdata: updated matrix
//
// One item per cycle sustained while m_axis does not stall. An item is held in
// the input register and then in the result register that drives m_axis.
// The mixing multipliers, rounding and saturation sit between those two
// registers. A stall on m_axis holds the result register and backs up into
// the input register; s_axis_tready drops only when both are full.
// Reset clears the valid flags only.
module rotation_matrix_axial_update_core
  import rmau_pkg::*;
#(
  parameter int unsigned ELEMENT_WIDTH = 18,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // tdata, low bit up: m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
  //   m_r2c0, m_r2c1, m_r2c2, sine, cosine, zero fill
  input  logic [((11*ELEMENT_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  // tuser: op
  input  logic [OP_W-1:0]                         s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // tdata, low bit up: r_r0c0, r_r0c1, r_r0c2, r_r1c0, r_r1c1, r_r1c2,
  //   r_r2c0, r_r2c1, r_r2c2, zero fill
  output logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0]    m_axis_tdata
);

  localparam int unsigned EW    = ELEMENT_WIDTH;
  localparam int unsigned FB    = FRACTION_BITS;
  localparam int unsigned IN_W  = 11 * EW;
  localparam int unsigned RES_W = 9 * EW;
  localparam int unsigned OUT_W = ((9 * EW + 7) / 8) * 8;
  localparam int unsigned PW    = 2 * EW;
  // sum width: room for two products plus carry, and for the rounding half
  localparam int unsigned SW    = (2 * EW + 2 > FB + 2) ? 2 * EW + 2 : FB + 2;

  localparam logic signed [SW-1:0] MAXV = {{(SW-EW+1){1'b0}}, {(EW-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(SW-EW+1){1'b1}}, {(EW-1){1'b0}}};
  localparam logic signed [SW-1:0] HALF = {{(SW-1){1'b0}}, 1'b1} << (FB - 1);

  // round(a*c +/- b*s) at FB fraction bits, ties up, saturated to EW bits
  function automatic logic signed [EW-1:0] mix_elem(
    input logic signed [EW-1:0] a,
    input logic signed [EW-1:0] b,
    input logic signed [EW-1:0] c,
    input logic signed [EW-1:0] s,
    input logic                 sub
  );
    logic signed [PW-1:0] ac;
    logic signed [PW-1:0] bs;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] rnd;
    logic signed [EW-1:0] res;
    ac  = PW'(a) * PW'(c);
    bs  = PW'(b) * PW'(s);
    sum = sub ? (SW'(ac) - SW'(bs) + HALF) : (SW'(ac) + SW'(bs) + HALF);
    rnd = sum >>> FB;
    if (rnd > MAXV) begin
      res = MAXV[EW-1:0];
    end else if (rnd < MINV) begin
      res = MINV[EW-1:0];
    end else begin
      res = rnd[EW-1:0];
    end
    return res;
  endfunction

  logic                  in_valid_q;
  logic [IN_W-1:0]       in_data_q;
  logic [OP_W-1:0]       in_op_q;
  logic                  out_valid_q;
  logic [RES_W-1:0]      out_data_q;
  logic [RES_W-1:0]      out_data_d;
  logic                  advance;

  logic signed [EW-1:0]  m     [3][3];
  logic signed [EW-1:0]  r     [3][3];
  logic signed [EW-1:0]  a_ln  [3];
  logic signed [EW-1:0]  b_ln  [3];
  logic signed [EW-1:0]  na_ln [3];
  logic signed [EW-1:0]  nb_ln [3];
  logic signed [EW-1:0]  sine;
  logic signed [EW-1:0]  cosine;
  mix_sel_t              sel;

  // move the input item on when the result register is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // hold the accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata[IN_W-1:0];
      in_op_q   <= s_axis_tuser;
    end
  end

  // unpack the matrix and the angle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        m[i][k] = in_data_q[(i*3+k)*EW +: EW];
      end
    end
    sine   = in_data_q[9*EW +: EW];
    cosine = in_data_q[10*EW +: EW];
  end

  // decode the op into the mixing pair
  always_comb begin
    sel = '{en: 1'b1, left: 1'b0, p: 2'd0, q: 2'd0};
    unique case (in_op_q)
      OP_RIGHT_X: begin sel.p = 2'd1; sel.q = 2'd2; end
      OP_RIGHT_Y: begin sel.p = 2'd2; sel.q = 2'd0; end
      OP_RIGHT_Z: begin sel.p = 2'd0; sel.q = 2'd1; end
      OP_LEFT_X:  begin sel.left = 1'b1; sel.p = 2'd2; sel.q = 2'd1; end
      OP_LEFT_Y:  begin sel.left = 1'b1; sel.p = 2'd0; sel.q = 2'd2; end
      OP_LEFT_Z:  begin sel.left = 1'b1; sel.p = 2'd1; sel.q = 2'd0; end
      default:    sel.en = 1'b0;
    endcase
  end

  // pick the two mixed elements on each crossing line and mix them
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (sel.left) begin
        a_ln[k] = m[sel.p][k];
        b_ln[k] = m[sel.q][k];
      end else begin
        a_ln[k] = m[k][sel.p];
        b_ln[k] = m[k][sel.q];
      end
      na_ln[k] = mix_elem(a_ln[k], b_ln[k], cosine, sine, 1'b0);
      nb_ln[k] = mix_elem(b_ln[k], a_ln[k], cosine, sine, 1'b1);
    end
  end

  // write the mixed elements back; the rest pass through
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        r[i][k] = m[i][k];
      end
    end
    if (sel.en) begin
      for (int k = 0; k < 3; k++) begin
        if (sel.left) begin
          r[sel.p][k] = na_ln[k];
          r[sel.q][k] = nb_ln[k];
        end else begin
          r[k][sel.p] = na_ln[k];
          r[k][sel.q] = nb_ln[k];
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        out_data_d[(i*3+k)*EW +: EW] = r[i][k];
      end
    end
  end

  // hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(out_data_q);

endmodule

>>> verif/rotation_matrix_axial_update_core_test.sv
`timescale 1ns / 1ps
// Testbench for rotation_matrix_axial_update_core: streams matrix items through the core
// and checks every result against a predictor of the axis rotation update.
// Depends on rmau_pkg and rotation_matrix_axial_update_core.
module rotation_matrix_axial_update_core_test
  import rmau_pkg::*;
();

  localparam int EW = 18;
  localparam int FB = 16;
  localparam int IN_W = ((11 * EW + 7) / 8) * 8;
  localparam int OUT_W = ((9 * EW + 7) / 8) * 8;
  localparam int SINE_IDX = 9;
  localparam int COSINE_IDX = 10;
  localparam longint ELEM_MAX = (longint'(1) << (EW - 1)) - 1;
  localparam longint ELEM_MIN = -(longint'(1) << (EW - 1));
  localparam int RANDOM_ITEMS = 1430;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 64;

  // codes above the left Z op mix nothing
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef logic signed [EW-1:0] elem_t;
  // element k = row * 3 + column, element 0 in the lowest bits
  typedef logic [8:0][EW-1:0] matrix_t;
  // matrix elements, then sine, then cosine
  typedef logic [10:0][EW-1:0] operand_t;

  // Predict each updated matrix and check results in order of arrival.
  class matrix_update_board;
    matrix_t pending_matrices[$];
    int unsigned failures = 0;

    // round a*c +/- b*s to nearest (ties up) and clamp to the element range
    static function elem_t mixed(elem_t a, elem_t b, elem_t c, elem_t s, bit minus);
      longint acc;
      longint r;
      acc = longint'(a) * longint'(c);
      if (minus) acc -= longint'(b) * longint'(s);
      else acc += longint'(b) * longint'(s);
      r = (acc + (longint'(1) << (FB - 1))) >>> FB;
      if (r > ELEM_MAX) r = ELEM_MAX;
      if (r < ELEM_MIN) r = ELEM_MIN;
      return elem_t'(r);
    endfunction

    static function matrix_t rotated_matrix(logic [OP_W-1:0] op, operand_t opnd);
      matrix_t res;
      elem_t s;
      elem_t c;
      bit left;
      bit en;
      int p;
      int q;
      res = opnd[8:0];
      s = opnd[SINE_IDX];
      c = opnd[COSINE_IDX];
      en = 1'b1;
      left = 1'b0;
      p = 0;
      q = 0;
      // pick the two mixed lines: columns for right, rows for left
      case (op)
        OP_RIGHT_X: begin p = 1; q = 2; end
        OP_RIGHT_Y: begin p = 2; q = 0; end
        OP_RIGHT_Z: begin p = 0; q = 1; end
        OP_LEFT_X: begin left = 1'b1; p = 2; q = 1; end
        OP_LEFT_Y: begin left = 1'b1; p = 0; q = 2; end
        OP_LEFT_Z: begin left = 1'b1; p = 1; q = 0; end
        default: en = 1'b0;
      endcase
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          if (left) begin
            res[p*3+k] = mixed(opnd[p*3+k], opnd[q*3+k], c, s, 1'b0);
            res[q*3+k] = mixed(opnd[q*3+k], opnd[p*3+k], c, s, 1'b1);
          end else begin
            res[k*3+p] = mixed(opnd[k*3+p], opnd[k*3+q], c, s, 1'b0);
            res[k*3+q] = mixed(opnd[k*3+q], opnd[k*3+p], c, s, 1'b1);
          end
        end
      end
      return res;
    endfunction

    function void record_input(logic [OP_W-1:0] op, operand_t opnd);
      pending_matrices.push_back(rotated_matrix(op, opnd));
    endfunction

    function void check_result(matrix_t got);
      matrix_t want;
      if (pending_matrices.size() == 0) begin
        $error("result with no item pending: %h", got);
        failures++;
        return;
      end
      want = pending_matrices.pop_front();
      for (int k = 0; k < 9; k++) begin
        if (got[k] !== want[k]) begin
          $error("r_r%0dc%0d: expected %0d, got %0d", k / 3, k % 3,
                 elem_t'(want[k]), elem_t'(got[k]));
          failures++;
        end
      end
    endfunction

    function int unsigned pending();
      return pending_matrices.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic [OP_W-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;

  matrix_update_board board;
  bit source_gaps;
  bit sink_stalls;
  bit hold_off_req;
  int unsigned quiet_cycles;

  rotation_matrix_axial_update_core DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Reset once at the start, then release it.
  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Note accepted items and check accepted results on the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        board.record_input(s_axis_tuser, s_axis_tdata[11*EW-1:0]);
      if (m_axis_tvalid && m_axis_tready)
        board.check_result(m_axis_tdata[9*EW-1:0]);
    end
  end

  // Stop a run in which nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL rotation_matrix_axial_update_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic elem_t rand_elem(int kind);
    case (kind)
      0: return elem_t'(int'($urandom_range(0, 131072)) - 65536);
      1: return elem_t'($urandom_range(0, (1 << EW) - 1));
      default: begin
        case ($urandom_range(0, 4))
          0: return elem_t'(ELEM_MAX);
          1: return elem_t'(ELEM_MIN);
          2: return elem_t'(0);
          3: return elem_t'(1);
          default: return elem_t'(-1);
        endcase
      end
    endcase
  endfunction

  // sine or cosine: mostly within one, sometimes exactly one, minus one or zero, sometimes any 18-bit value
  function automatic elem_t rand_trig();
    case ($urandom_range(0, 11))
      0: return rand_elem(1);
      1: begin
        case ($urandom_range(0, 2))
          0: return elem_t'(65536);
          1: return elem_t'(-65536);
          default: return elem_t'(0);
        endcase
      end
      default: return rand_elem(0);
    endcase
  endfunction

  function automatic operand_t uniform_operand(elem_t value, elem_t s, elem_t c);
    operand_t opnd;
    for (int k = 0; k < 9; k++) opnd[k] = value;
    opnd[SINE_IDX] = s;
    opnd[COSINE_IDX] = c;
    return opnd;
  endfunction

  // Offer one item, with an optional gap first; return once it is accepted.
  task automatic send_item(input logic [OP_W-1:0] op, input operand_t opnd);
    if (source_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {{(IN_W - 11 * EW){1'b0}}, opnd};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin
    operand_t opnd;
    logic [OP_W-1:0] op;
    int kind;
    board = new;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_RIGHT_X;
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    hold_off_req = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);

    // every op code on a full-range matrix, 30 degree angle
    for (int o = 0; o <= OP_SPARE_HI; o++) begin
      for (int k = 0; k < 9; k++) opnd[k] = rand_elem(1);
      opnd[SINE_IDX] = elem_t'(32768);
      opnd[COSINE_IDX] = elem_t'(56756);
      send_item(o[OP_W-1:0], opnd);
    end

    // saturation at both ends, sign extremes, out-of-range sine and cosine
    send_item(OP_RIGHT_X, uniform_operand(elem_t'(ELEM_MAX), elem_t'(65536),
                                          elem_t'(65536)));
    send_item(OP_LEFT_Y, uniform_operand(elem_t'(ELEM_MIN), elem_t'(65536),
                                         elem_t'(65536)));
    send_item(OP_RIGHT_Z, uniform_operand(elem_t'(ELEM_MIN), elem_t'(-65536),
                                          elem_t'(-65536)));
    send_item(OP_LEFT_X, uniform_operand(elem_t'(ELEM_MAX), elem_t'(ELEM_MIN),
                                         elem_t'(ELEM_MAX)));
    // exact halves: ties round toward plus infinity; then a zero matrix and an identity rotation
    send_item(OP_RIGHT_Y, uniform_operand(elem_t'(1), elem_t'(0), elem_t'(32768)));
    send_item(OP_LEFT_Z, uniform_operand(elem_t'(-1), elem_t'(0), elem_t'(32768)));
    send_item(OP_RIGHT_X, uniform_operand(elem_t'(0), elem_t'(0), elem_t'(0)));
    send_item(OP_LEFT_Z, uniform_operand(elem_t'(ELEM_MAX), elem_t'(0), elem_t'(65536)));
    // spare codes pass the matrix through
    send_item(OP_SPARE_LO, uniform_operand(elem_t'(ELEM_MIN), elem_t'(65536),
                                           elem_t'(-65536)));
    send_item(OP_SPARE_HI, uniform_operand(elem_t'(ELEM_MAX), elem_t'(ELEM_MIN),
                                           elem_t'(ELEM_MAX)));
    // alternating signs so the mixed pair pulls apart
    for (int k = 0; k < 9; k++) opnd[k] = (k % 2) ? elem_t'(ELEM_MIN) : elem_t'(ELEM_MAX);
    opnd[SINE_IDX] = elem_t'(65536);
    opnd[COSINE_IDX] = elem_t'(65536);
    send_item(OP_RIGHT_Y, opnd);

    // random items: idling in alternating stretches, none in the last part
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      source_gaps = ((i / 150) % 2 == 0) && (i < RANDOM_ITEMS - 300);
      sink_stalls = ((i / 150) % 2 == 0) && (i < RANDOM_ITEMS - 300);
      if (i == 500) hold_off_req = 1'b1;
      op = ($urandom_range(0, 9) == 0) ? OP_W'(OP_SPARE_LO + $urandom_range(0, 1))
                                       : OP_W'($urandom_range(OP_RIGHT_X, OP_LEFT_Z));
      kind = $urandom_range(0, 9);
      for (int k = 0; k < 9; k++) begin
        if (kind <= 5) opnd[k] = rand_elem(0);
        else if (kind <= 7) opnd[k] = rand_elem(1);
        else if (kind == 8) opnd[k] = rand_elem(2);
        else opnd[k] = rand_elem($urandom_range(0, 2));
      end
      opnd[SINE_IDX] = rand_trig();
      opnd[COSINE_IDX] = rand_trig();
      send_item(op, opnd);
    end
    s_axis_tvalid <= 1'b0;

    // drain, then let the pipeline settle
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (board.failures == 0) begin
      $display("PASS rotation_matrix_axial_update_core");
    end else begin
      $display("FAIL rotation_matrix_axial_update_core");
    end
    $finish;
  end

endmodule
